[hdl/icn_pkg.sv]
// Shared types and constants for the identifier character normalizer.
`timescale 1ns / 1ps
package icn_pkg;

  // Name policy codes
  localparam logic [1:0] PolicyPreserve   = 2'd0;
  localparam logic [1:0] PolicyLowerSnake = 2'd1;
  localparam logic [1:0] PolicyLowerAlpha = 2'd2;
  localparam logic [1:0] PolicyReset      = PolicyLowerSnake;

  // Longest burst one input byte can cause: "field_" plus the digit
  localparam int unsigned BurstLen = 7;
  localparam int unsigned IdxW     = $clog2(BurstLen);

  localparam logic [7:0] ChUnderscore = 8'h5f;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChUpperA     = 8'h41;
  localparam logic [7:0] ChUpperZ     = 8'h5a;
  localparam logic [7:0] ChLowerA     = 8'h61;
  localparam logic [7:0] ChLowerZ     = 8'h7a;
  localparam logic [7:0] CaseBit      = 8'h20;

  // "field", first letter in entry 0
  localparam logic [4:0][7:0] WordField = {8'h64, 8'h6c, 8'h65, 8'h69, 8'h66};

  // One burst of result bytes for one accepted request
  typedef struct packed {
    logic [BurstLen-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;  // number of bytes minus one
    logic                     present;   // 0 only for a bare end marker
    logic                     done;      // name ends on the last byte
  } burst_t;

endpackage

[hdl/icn_planner.sv]
// Per-name state and the single-pass classification of one input byte.
`timescale 1ns / 1ps
module icn_planner
  import icn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] policy_i,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       present_i,
  input  logic       end_i,
  output logic       emit_o,
  output burst_t     burst_o
);

  logic emitted_q, emitted_d;
  logic last_us_q, last_us_d;
  logic held_q, held_d;

  logic is_upper, is_lower, is_digit, is_us, maps_us, kept;
  logic [7:0] low_c;

  // Character classes
  always_comb begin
    is_upper = (byte_i >= ChUpperA) && (byte_i <= ChUpperZ);
    is_lower = (byte_i >= ChLowerA) && (byte_i <= ChLowerZ);
    is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
    is_us    = (byte_i == ChUnderscore);
    maps_us  = is_us || !(is_upper || is_lower || is_digit);
    low_c    = is_upper ? (byte_i | CaseBit) : byte_i;
  end

  // Burst and next state
  always_comb begin
    burst_o          = '0;
    burst_o.present  = 1'b1;
    burst_o.done     = end_i;
    kept             = 1'b0;
    emitted_d        = emitted_q;
    last_us_d        = last_us_q;
    held_d           = held_q;
    case (policy_i)
      PolicyPreserve: begin
        if (present_i) begin
          kept              = 1'b1;
          burst_o.bytes[0]  = byte_i;
          emitted_d         = 1'b1;
        end
      end
      PolicyLowerSnake: begin
        if (present_i) begin
          if (maps_us) begin
            if (!last_us_q && emitted_q) begin
              held_d = 1'b1;
            end
            last_us_d = 1'b1;
          end else begin
            kept = 1'b1;
            if (!emitted_q && is_digit) begin
              // leading digit gets the "field_" prefix
              for (int i = 0; i < 5; i++) begin
                burst_o.bytes[i] = WordField[i];
              end
              burst_o.bytes[5]  = ChUnderscore;
              burst_o.bytes[6]  = low_c;
              burst_o.last_idx  = IdxW'(6);
            end else if (held_q) begin
              burst_o.bytes[0]  = ChUnderscore;
              burst_o.bytes[1]  = low_c;
              burst_o.last_idx  = IdxW'(1);
            end else begin
              burst_o.bytes[0]  = low_c;
            end
            held_d    = 1'b0;
            emitted_d = 1'b1;
            last_us_d = 1'b0;
          end
        end
      end
      default: begin
        // lower alpha; the unused code behaves the same
        if (present_i && (is_upper || is_lower)) begin
          kept             = 1'b1;
          burst_o.bytes[0] = low_c;
          emitted_d        = 1'b1;
        end
      end
    endcase

    // Closing request that keeps no byte of its own
    if (end_i && !kept) begin
      if (!emitted_q && (policy_i != PolicyPreserve)) begin
        for (int i = 0; i < 5; i++) begin
          burst_o.bytes[i] = WordField[i];
        end
        burst_o.last_idx = IdxW'(4);
      end else begin
        burst_o.present = 1'b0;
      end
    end

    if (end_i) begin
      emitted_d = 1'b0;
      last_us_d = 1'b0;
      held_d    = 1'b0;
    end
    emit_o = kept || end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitted_q <= 1'b0;
      last_us_q <= 1'b0;
      held_q    <= 1'b0;
    end else if (accept_i) begin
      emitted_q <= emitted_d;
      last_us_q <= last_us_d;
      held_q    <= held_d;
    end
  end

endmodule

[hdl/icn_emitter.sv]
// One-burst result register; hands out a byte per cycle while ready_i.
`timescale 1ns / 1ps
module icn_emitter
  import icn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  output logic       in_ready_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] byte_o,
  output logic       present_o,
  output logic       done_o
);

  burst_t          burst_q;
  logic            valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            at_last, take;

  assign at_last    = (idx_q == burst_q.last_idx);
  assign take       = valid_q && ready_i;
  assign in_ready_o = !valid_q || (ready_i && at_last);

  assign valid_o   = valid_q;
  assign byte_o    = burst_q.bytes[idx_q];
  assign present_o = burst_q.present;
  assign done_o    = burst_q.done && at_last;

  // Walk the burst; a new one loads as the old one's last byte leaves
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (take) begin
      if (at_last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

[hdl/identifier_char_normalizer.sv]
// Top level of the identifier character normalizer.
`timescale 1ns / 1ps
// Takes a field name one byte per request and streams out the cleaned name,
// under the policy in the config register (0 preserve, 1 lower snake case,
// 2 lowercase letters only, 3 acts as 2; reset 1). Each name is closed by a
// request with tlast set; the result's last byte carries tlast, and a name
// that yields nothing closes with a bare marker (tuser 0) or "field". Rate:
// one request per cycle while the receiver is ready and each request yields
// at most one result byte; one that yields more (up to seven, for "field_"
// before a leading digit) holds the input until its last byte leaves; the
// single result register hands out one byte per cycle while the receiver
// is ready. Write the config register only while the block is idle.
module identifier_char_normalizer
  import icn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,    // name_policy
  // input byte stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // byte_value
  input  logic       s_axis_tuser,  // byte_present
  input  logic       s_axis_tlast,  // name_end
  // result byte stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_byte
  output logic       m_axis_tuser,  // out_present
  output logic       m_axis_tlast   // name_done
);

  logic [1:0] policy_q;
  logic       accept, emit;
  burst_t     burst;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  // Policy register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolicyReset;
    end else if (cfg_valid_i) begin
      policy_q <= cfg_data_i;
    end
  end

  icn_planner u_planner (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .policy_i  (policy_q),
    .accept_i  (accept),
    .byte_i    (s_axis_tdata),
    .present_i (s_axis_tuser),
    .end_i     (s_axis_tlast),
    .emit_o    (emit),
    .burst_o   (burst)
  );

  icn_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && emit),
    .burst_i    (burst),
    .in_ready_o (s_axis_tready),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .byte_o     (m_axis_tdata),
    .present_o  (m_axis_tuser),
    .done_o     (m_axis_tlast)
  );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the identifier character normalizer.
`timescale 1ns / 1ps
module tb_top;
  import icn_pkg::*;

  // Policy value with no name of its own in the package; acts as lower alpha
  localparam logic [1:0] PolicyUnused = 2'd3;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned LongHold     = 120;

  typedef struct packed {
    logic [7:0] value;
    logic       present;
    logic       done;
  } clean_byte_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i    = 2'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'd0;   // byte_value
  logic       s_axis_tuser  = 1'b0;   // byte_present
  logic       s_axis_tlast  = 1'b0;   // name_end
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // out_byte
  logic       m_axis_tuser;           // out_present
  logic       m_axis_tlast;           // name_done

  identifier_char_normalizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the block's policy register and per-name flags
  logic [1:0]  name_policy = PolicyReset;
  logic        emitted_any = 1'b0;
  logic        last_underscore = 1'b0;
  logic        held_underscore = 1'b0;

  clean_byte_t burst_q[$];
  clean_byte_t cleaned_q[$];

  bit          idle_en = 1'b1;
  int unsigned hold_request = 0;
  int unsigned err_cnt = 0;
  int unsigned requests_sent = 0;
  int unsigned names_sent = 0;
  int unsigned results_seen = 0;

  function automatic logic is_upper(logic [7:0] c);
    return c >= ChUpperA && c <= ChUpperZ;
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return c >= ChLowerA && c <= ChLowerZ;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic void emit_clean(logic [7:0] c);
    clean_byte_t b;
    b.value   = c;
    b.present = 1'b1;
    b.done    = 1'b0;
    burst_q   = {burst_q, b};
    emitted_any = 1'b1;
  endfunction

  function automatic void emit_word_field();
    for (int i = 0; i < 5; i++) emit_clean(WordField[i]);
  endfunction

  // Lower snake: map, collapse underscores, hold one back until a kept byte follows
  function automatic void snake_step(logic [7:0] c);
    logic [7:0] m;
    if (is_upper(c)) m = c | CaseBit;
    else if (is_lower(c) || is_digit(c) || c == ChUnderscore) m = c;
    else m = ChUnderscore;

    if (m == ChUnderscore) begin
      if (!last_underscore && emitted_any) held_underscore = 1'b1;
      last_underscore = 1'b1;
    end else begin
      if (held_underscore) begin
        emit_clean(ChUnderscore);
        held_underscore = 1'b0;
      end
      if (!emitted_any && is_digit(m)) begin
        emit_word_field();
        emit_clean(ChUnderscore);
      end
      emit_clean(m);
      last_underscore = 1'b0;
    end
  endfunction

  // Expected result bytes of one accepted request, appended to cleaned_q
  function automatic void predict_cleaned(logic [7:0] c, logic present, logic name_end);
    clean_byte_t marker;
    burst_q.delete();
    if (present) begin
      case (name_policy)
        PolicyPreserve:   emit_clean(c);
        PolicyLowerSnake: snake_step(c);
        default: begin
          if (is_upper(c)) emit_clean(c | CaseBit);
          else if (is_lower(c)) emit_clean(c);
        end
      endcase
    end
    if (name_end) begin
      if (burst_q.size() == 0) begin
        if (!emitted_any && name_policy != PolicyPreserve) emit_word_field();
        else begin
          marker  = '{value: 8'd0, present: 1'b0, done: 1'b0};
          burst_q = {burst_q, marker};
        end
      end
      burst_q[burst_q.size() - 1].done = 1'b1;
      emitted_any     = 1'b0;
      last_underscore = 1'b0;
      held_underscore = 1'b0;
    end
    cleaned_q = {cleaned_q, burst_q};
  endfunction

  // Send one request; valid stays high afterwards unless an idle burst lowers it
  task automatic send_item(input logic [7:0] c, input logic present, input logic name_end);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= present;
    s_axis_tlast  <= name_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_cleaned(c, present, name_end);
    requests_sent++;
    if (name_end) names_sent++;
  endtask

  task automatic send_text(input string text, input logic end_on_last);
    for (int i = 0; i < text.len(); i++)
      send_item(text[i], 1'b1, end_on_last && (i == text.len() - 1));
  endtask

  task automatic send_end_marker();
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Hold the sender until every expected result has come, then let the block settle
  task automatic wait_for_results();
    int unsigned guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (cleaned_q.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (cleaned_q.size() != 0) begin
      $error("%0d expected result bytes never arrived", cleaned_q.size());
      err_cnt++;
      cleaned_q.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_policy(input logic [1:0] policy);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= policy;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    name_policy = policy;
  endtask

  // Byte mix for random names: mostly identifier characters, some punctuation and raw bytes
  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(ChLowerA, ChLowerZ));
      3, 4:    return 8'($urandom_range(ChUpperA, ChUpperZ));
      5:       return 8'($urandom_range(ChZero, ChNine));
      6:       return ChUnderscore;
      7: begin
        case ($urandom_range(0, 3))
          0:       return 8'h2d;  // '-'
          1:       return 8'h20;  // space
          2:       return 8'h2e;  // '.'
          default: return 8'h24;  // '$'
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random name, closed either on its last byte or by a separate end request
  task automatic send_random_name(input int unsigned max_len);
    int unsigned len;
    logic        sep_end;
    logic [7:0]  c;
    len     = $urandom_range(0, max_len);
    sep_end = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      c = pick_name_char();
      if (i == 0 && $urandom_range(0, 3) == 0) c = 8'($urandom_range(ChZero, ChNine));
      send_item(c, 1'b1, !sep_end && (i == len - 1));
    end
    if (sep_end) send_end_marker();
  endtask

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    clean_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (cleaned_q.size() == 0) begin
        $error("unexpected result byte %02h present %0b done %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        err_cnt++;
      end else begin
        want = cleaned_q.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("out_byte: expected %02h, got %02h", want.value, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser !== want.present) begin
          $error("out_present: expected %0b, got %0b", want.present, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tlast !== want.done) begin
          $error("name_done: expected %0b, got %0b", want.done, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Receiver ready: random stall bursts, plus a long hold when a test asks for one
  always @(posedge clk_i) begin : ready_gen
    int unsigned stall_left;
    if (hold_request != 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Snake policy out of reset: case folding, collapsing, leading digit, raw extremes
  task automatic test_snake_directed();
    send_text("Ab_9", 1'b1);
    send_text("_-x", 1'b0);
    send_item(8'hff, 1'b0, 1'b0);           // empty request mid-name
    send_text(" y_", 1'b0);
    send_end_marker();                       // trailing underscore dropped, bare end
    send_text("7", 1'b1);                    // leading digit gets the prefix
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_end_marker();                       // nothing kept: becomes "field"
    send_end_marker();                       // empty name
  endtask

  // Remaining policies, the unused code, and a policy switch in the middle of a name
  task automatic test_policy_directed();
    write_policy(PolicyPreserve);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_end_marker();                       // empty name under preserve: bare end
    write_policy(PolicyLowerAlpha);
    send_text("Q1z", 1'b1);
    write_policy(PolicyUnused);
    send_text("%", 1'b1);
    write_policy(PolicyLowerSnake);
    send_text("a-", 1'b0);
    write_policy(PolicyPreserve);
    send_text("-", 1'b1);                    // held underscore dropped at the end
  endtask

  task automatic test_random_policies();
    logic [1:0] order[4] = '{PolicyLowerSnake, PolicyPreserve, PolicyUnused, PolicyLowerAlpha};
    foreach (order[p]) begin
      write_policy(order[p]);
      repeat (10) send_random_name(10);
    end
  endtask

  // Receiver holds off long while the sender keeps offering prefix-heavy names
  task automatic test_output_backpressure();
    write_policy(PolicyLowerSnake);
    hold_request = LongHold;
    for (int i = 0; i < 8; i++) begin
      send_item(8'($urandom_range(ChZero, ChNine)), 1'b1, 1'b0);
      send_random_name(4);
    end
    wait_for_results();
    hold_request = LongHold;
    repeat (6) send_random_name(8);
  endtask

  task automatic test_quiet_finish();
    wait_for_results();
    idle_en = 1'b0;
    repeat (6) send_random_name(10);
    write_policy(PolicyLowerAlpha);
    repeat (4) send_random_name(10);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_snake_directed();
    test_policy_directed();
    test_random_policies();
    test_output_backpressure();
    test_quiet_finish();
    wait_for_results();
    $display("Ran %0d requests over %0d names, checked %0d result bytes,",
             requests_sent, names_sent, results_seen);
    $display("covering all four policy codes, idle bursts and long output stalls.");
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
